// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the elevator scheduler RTL.
// Needs no other file; the bodies compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define ASSERT_AT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("%m: property failed");
// Condition must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
        else $error("%m: forbidden condition seen");
`else
`define ASSERT_AT(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

// ===== rtl/core/efs_pkg.sv =====
// Types, constants and helper functions for the elevator floor scheduler.
// Used by every module of the block; depends on nothing.
`default_nettype none
package efs_pkg;

    localparam int FLOORS  = 12;
    localparam int FLOOR_W = $clog2(FLOORS + 1);
    localparam int TIMER_W = 16;
    localparam int TICK_W  = 10;

    localparam logic [TIMER_W-1:0] DOOR_HOLD_RST   = TIMER_W'(3000);
    localparam logic [TIMER_W-1:0] MOVE_PERIOD_RST = TIMER_W'(3000);
    localparam logic [TICK_W-1:0]  TICK_RST        = TICK_W'(30);
    localparam logic [FLOOR_W-1:0] START_FLOOR_RST = FLOOR_W'(1);

    typedef logic [FLOORS-1:0]  t_map;
    typedef logic [FLOOR_W-1:0] t_floor;
    typedef logic [TIMER_W-1:0] t_timer;

    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_REQUEST = 2'd1,
        OP_EXTEND  = 2'd2,
        OP_CLOSE   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        DIR_IDLE = 2'd0,
        DIR_UP   = 2'd1,
        DIR_DN   = 2'd2
    } t_dir;

    typedef enum logic [1:0] {
        REG_DOOR_HOLD   = 2'd0,
        REG_MOVE_PERIOD = 2'd1,
        REG_TICK        = 2'd2,
        REG_START_FLOOR = 2'd3
    } t_reg_idx;

    // Timer settings and the start floor as held by the register file.
    typedef struct packed {
        t_timer              door_hold;
        t_timer              move_period;
        logic [TICK_W-1:0]   tick;
        logic [FLOOR_W-1:0]  start_floor;
    } t_cfg;

    // Request from the register file to place the car on a floor.
    typedef struct packed {
        logic   wr;
        t_floor floor;
    } t_floor_set;

    // Scheduler state carried from one item to the next.
    typedef struct packed {
        t_map   pending;
        t_floor floor;
        t_dir   dir;
        logic   door_open;
        t_timer door_timer;
        t_timer move_timer;
    } t_state;

    // One result beat.
    typedef struct packed {
        t_map   pending;
        logic   taken;
        t_floor served_floor;
        logic   served;
        logic   door_open;
        t_dir   direction;
        t_floor car_floor;
    } t_result;

    function automatic t_floor clamp_floor(input t_floor v);
        t_floor r;
        if (v == '0) begin
            r = t_floor'(1);
        end else if (v > t_floor'(FLOORS)) begin
            r = t_floor'(FLOORS);
        end else begin
            r = v;
        end
        return r;
    endfunction

    // Bit mask of the floors strictly above floor f.
    function automatic t_map above_mask(input t_floor f);
        t_map m;
        for (int i = 0; i < FLOORS; i++) begin
            m[i] = (FLOOR_W'(i + 1) > f);
        end
        return m;
    endfunction

    // Bit mask of the floors strictly below floor f.
    function automatic t_map below_mask(input t_floor f);
        t_map m;
        for (int i = 0; i < FLOORS; i++) begin
            m[i] = (FLOOR_W'(i + 1) < f);
        end
        return m;
    endfunction

    function automatic t_map floor_bit(input t_floor f);
        return t_map'(1) << (f - t_floor'(1));
    endfunction

    // Lowest pending floor in the mask, zero for an empty mask.
    function automatic t_floor lowest_floor(input t_map m);
        t_floor r;
        r = '0;
        for (int i = FLOORS - 1; i >= 0; i--) begin
            if (m[i]) begin
                r = FLOOR_W'(i + 1);
            end
        end
        return r;
    endfunction

    // Highest pending floor in the mask, zero for an empty mask.
    function automatic t_floor highest_floor(input t_map m);
        t_floor r;
        r = '0;
        for (int i = 0; i < FLOORS; i++) begin
            if (m[i]) begin
                r = FLOOR_W'(i + 1);
            end
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/efs_cfg_regs.sv =====
// APB register file for the scheduler timers and the start floor.
// Depends on efs_pkg for the register map and the settings struct.
`default_nettype none
module efs_cfg_regs
    import efs_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output t_cfg             o_cfg,
    output t_floor_set       o_floor_set
);

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_reg_idx'(paddr[3:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;

    // Register writes in the access phase.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.door_hold   <= DOOR_HOLD_RST;
            r_cfg.move_period <= MOVE_PERIOD_RST;
            r_cfg.tick        <= TICK_RST;
            r_cfg.start_floor <= START_FLOOR_RST;
        end else if (w_wr) begin
            case (w_idx)
                REG_DOOR_HOLD:   r_cfg.door_hold   <= pwdata[TIMER_W-1:0];
                REG_MOVE_PERIOD: r_cfg.move_period <= pwdata[TIMER_W-1:0];
                REG_TICK:        r_cfg.tick        <= pwdata[TICK_W-1:0];
                REG_START_FLOOR: r_cfg.start_floor <= pwdata[FLOOR_W-1:0];
                default: ;
            endcase
        end
    end

    // A start floor write places the car at once, clamped into the shaft.
    assign o_floor_set.wr    = w_wr && (w_idx == REG_START_FLOOR);
    assign o_floor_set.floor = clamp_floor(pwdata[FLOOR_W-1:0]);
    assign o_cfg             = r_cfg;

    // Read back.
    always_comb begin
        case (w_idx)
            REG_DOOR_HOLD:   prdata = 32'(r_cfg.door_hold);
            REG_MOVE_PERIOD: prdata = 32'(r_cfg.move_period);
            REG_TICK:        prdata = 32'(r_cfg.tick);
            REG_START_FLOOR: prdata = 32'(r_cfg.start_floor);
            default:         prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/core/efs_step.sv =====
// Next-state and result logic for one scheduler item (tick, request,
// extend, close). Purely combinational; depends on efs_pkg.
`default_nettype none
module efs_step
    import efs_pkg::*;
(
    input  wire t_cfg         i_cfg,
    input  wire t_state       i_state,
    input  wire t_op          i_op,
    input  wire t_floor       i_floor,
    output t_state            o_state,
    output t_result           o_result
);

    t_map   w_up;
    t_map   w_dn;
    t_map   w_here;
    t_floor w_ud;
    t_floor w_dd;
    t_timer w_tick;

    // Pending floors on either side of the car, and the car's own bit.
    assign w_up   = i_state.pending & above_mask(i_state.floor);
    assign w_dn   = i_state.pending & below_mask(i_state.floor);
    assign w_here = floor_bit(i_state.floor);
    assign w_ud   = lowest_floor(w_up) - i_state.floor;
    assign w_dd   = i_state.floor - highest_floor(w_dn);
    assign w_tick = TIMER_W'(i_cfg.tick);

    always_comb begin
        t_state n;
        t_dir   dir;
        t_dir   opp;
        logic   ahead_any;
        logic   served;
        logic   taken;

        n      = i_state;
        served = 1'b0;
        taken  = 1'b0;
        dir    = i_state.dir;
        opp    = DIR_UP;
        ahead_any = 1'b0;

        case (i_op)
            OP_TICK: begin
                if (i_state.door_open) begin
                    // Door open: count the hold time down, close at zero.
                    if (i_state.door_timer <= w_tick) begin
                        n.door_timer = '0;
                        n.door_open  = 1'b0;
                    end else begin
                        n.door_timer = i_state.door_timer - w_tick;
                    end
                end else if (i_state.pending == '0) begin
                    n.dir = DIR_IDLE;
                end else begin
                    // Idle car picks a side; nearer side wins, ties go up.
                    if (dir == DIR_IDLE && (w_up != '0 || w_dn != '0)) begin
                        if (w_dn == '0) begin
                            dir = DIR_UP;
                        end else if (w_up == '0) begin
                            dir = DIR_DN;
                        end else begin
                            dir = (w_ud <= w_dd) ? DIR_UP : DIR_DN;
                        end
                        n.move_timer = i_cfg.move_period;
                    end
                    ahead_any = (dir == DIR_UP && w_up != '0) ||
                                (dir == DIR_DN && w_dn != '0);
                    if ((i_state.pending & w_here) != '0) begin
                        // Arrival at a pending floor.
                        n.door_open  = 1'b1;
                        n.door_timer = i_cfg.door_hold;
                        n.pending    = i_state.pending & ~w_here;
                        n.move_timer = i_cfg.move_period;
                        served       = 1'b1;
                        if (!ahead_any) begin
                            opp = (dir == DIR_UP) ? DIR_DN : DIR_UP;
                            if ((opp == DIR_UP && w_up != '0) ||
                                (opp == DIR_DN && w_dn != '0)) begin
                                dir = opp;
                            end else begin
                                dir = DIR_IDLE;
                            end
                        end
                    end else if (n.move_timer != '0) begin
                        n.move_timer = (n.move_timer > w_tick) ?
                                       n.move_timer - w_tick : '0;
                    end else if (!ahead_any) begin
                        dir = DIR_IDLE;
                    end else begin
                        n.floor      = (dir == DIR_UP) ? i_state.floor + t_floor'(1)
                                                       : i_state.floor - t_floor'(1);
                        n.move_timer = i_cfg.move_period;
                    end
                    n.dir = dir;
                end
            end
            OP_REQUEST: begin
                // Accept only a new floor inside the shaft, not the car's own.
                if (i_floor != '0 && i_floor <= t_floor'(FLOORS) &&
                    i_floor != i_state.floor &&
                    (i_state.pending & floor_bit(i_floor)) == '0) begin
                    n.pending = i_state.pending | floor_bit(i_floor);
                    taken     = 1'b1;
                end
            end
            OP_EXTEND: begin
                if (i_state.door_open) begin
                    n.door_timer = i_cfg.door_hold;
                end
            end
            OP_CLOSE: begin
                if (i_state.door_open) begin
                    n.door_open  = 1'b0;
                    n.door_timer = '0;
                end
            end
            default: ;
        endcase

        o_state               = n;
        o_result.pending      = n.pending;
        o_result.taken        = taken;
        o_result.served       = served;
        o_result.served_floor = served ? i_state.floor : '0;
        o_result.door_open    = n.door_open;
        o_result.direction    = n.dir;
        o_result.car_floor    = n.floor;
    end

endmodule
`default_nettype wire

// ===== rtl/core/elevator_floor_scheduler_core.sv =====
// Top level of the single-car elevator floor scheduler: input register,
// state, result register and APB settings. Uses efs_pkg, efs_cfg_regs,
// efs_step and assert_macros.svh.
//
//  channel  | direction | payload
//  ---------+-----------+-----------------------------------------------
//  s (in)   | sink      | tuser: op; tdata: floor
//  m (out)  | source    | tdata: car floor, direction, door, served, pending
//  apb      | slave     | four settings registers at byte addresses 0..12
//
// One beat in, one beat out; a new beat is taken every cycle unless the
// output stalls. A beat is first held in the input register and is then
// worked into the state and the result register, which offers its result.
// A stalled output holds the result and stops the input register only
// when that register is full. Reset is synchronous and leaves the car on
// floor 1, door shut, nothing pending.
`default_nettype none
`include "assert_macros.svh"
module elevator_floor_scheduler_core
    import efs_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Input stream.
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,  // [3:0] floor, [7:4] zero
    input  wire logic [1:0]  i_s_tuser,  // [1:0] op
    // Result stream.
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    // [3:0] car_floor, [5:4] direction, [6] door_open, [7] served,
    // [11:8] served_floor, [12] request_taken, [24:13] pending_floors,
    // [31:25] zero
    output logic      [31:0] o_m_tdata,
    // Settings port.
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    t_cfg       w_cfg;
    t_floor_set w_floor_set;
    t_state     r_state;
    t_state     n_state;
    t_result    n_result;
    t_result    r_result;
    logic       r_in_valid;
    t_op        r_in_op;
    t_floor     r_in_floor;
    logic       r_out_valid;
    logic       w_advance;

    efs_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_cfg       (w_cfg),
        .o_floor_set (w_floor_set)
    );

    efs_step u_step (
        .i_cfg    (w_cfg),
        .i_state  (r_state),
        .i_op     (r_in_op),
        .i_floor  (r_in_floor),
        .o_state  (n_state),
        .o_result (n_result)
    );

    // The held beat moves on when the result register is free or emptying.
    assign w_advance  = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || !r_out_valid || i_m_tready;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_op    <= t_op'(i_s_tuser);
            r_in_floor <= i_s_tdata[FLOOR_W-1:0];
        end
    end

    // Scheduler state; a start floor write places the car directly.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.pending    <= '0;
            r_state.floor      <= clamp_floor(START_FLOOR_RST);
            r_state.dir        <= DIR_IDLE;
            r_state.door_open  <= 1'b0;
            r_state.door_timer <= '0;
            r_state.move_timer <= MOVE_PERIOD_RST;
        end else if (w_floor_set.wr) begin
            r_state.floor <= w_floor_set.floor;
        end else if (w_advance) begin
            r_state <= n_state;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_result <= n_result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = 32'(r_result);

    // The car never leaves the shaft.
    `ASSERT_NEVER(a_floor_range, i_clk, i_rst_n,
        r_out_valid && (r_result.car_floor == '0 ||
                        r_result.car_floor > t_floor'(FLOORS)))
    // A served floor is the car's floor, with the door open.
    `ASSERT_AT(a_served_door, i_clk, i_rst_n,
        (r_out_valid && r_result.served) |->
        (r_result.door_open && r_result.served_floor == r_result.car_floor))
    // A tick that serves cannot also take a request.
    `ASSERT_NEVER(a_served_taken, i_clk, i_rst_n,
        r_out_valid && r_result.served && r_result.taken)
    // No floor is reported without the served flag.
    `ASSERT_NEVER(a_served_zero, i_clk, i_rst_n,
        r_out_valid && !r_result.served && r_result.served_floor != '0)

endmodule
`default_nettype wire

// ===== tb/tb_elevator_floor_scheduler_core.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the elevator floor scheduler core.
// Drives request, tick and door beats, predicts every result beat and checks it.
// Depends on efs_pkg and elevator_floor_scheduler_core only.
module tb_elevator_floor_scheduler_core;
    import efs_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;

    // Expected contents of one result beat.
    typedef struct packed {
        t_floor car_floor;
        t_dir   direction;
        logic   door_open;
        logic   served;
        t_floor served_floor;
        logic   taken;
        t_map   pending;
    } t_car_report;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata;   // [3:0] floor, [7:4] zero
    logic [1:0]  i_s_tuser;   // [1:0] op
    logic        o_m_tvalid;
    logic        i_m_tready;
    // [3:0] car_floor, [5:4] direction, [6] door_open, [7] served,
    // [11:8] served_floor, [12] request_taken, [24:13] pending_floors, [31:25] zero
    logic [31:0] o_m_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Predicted car state and settings.
    t_map              pend;
    t_floor            car_at;
    t_dir              dir;
    logic              door;
    t_timer            door_left;
    t_timer            move_left;
    t_timer            hold;
    t_timer            period;
    logic [TICK_W-1:0] tick_len;

    t_car_report reports_due[$];

    int mismatch_count = 0;
    int items_sent     = 0;
    int results_seen   = 0;
    int writes_done    = 0;
    int floors_served  = 0;
    int src_idle_pct   = 18;
    int sink_idle_pct  = 77;
    int calm_left      = 0;
    int quiet_cycles   = 0;

    elevator_floor_scheduler_core DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // 4 ns clock.
    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // Pending floors strictly ahead of the car in the given direction.
    function automatic t_map pending_ahead(input t_dir d);
        t_map m;
        for (int i = 0; i < FLOORS; i++) begin
            m[i] = pend[i] && ((d == DIR_UP && i + 1 > car_at) ||
                               (d == DIR_DN && i + 1 < car_at));
        end
        return m;
    endfunction

    // Distance from the car to the nearest floor of the mask on one side.
    function automatic int floor_gap(input t_map m, input t_dir d);
        int g;
        g = 0;
        if (d == DIR_UP) begin
            for (int f = FLOORS; f > car_at; f--) begin
                if (m[f-1]) g = f - car_at;
            end
        end else begin
            for (int f = 1; f < car_at; f++) begin
                if (m[f-1]) g = car_at - f;
            end
        end
        return g;
    endfunction

    // Works one accepted beat into the predicted state and builds its report.
    task automatic advance_car(input t_op op, input logic [3:0] req,
                               output t_car_report rpt);
        t_floor served_at;
        logic   taken;
        t_map   up_side;
        t_map   down_side;
        t_dir   other;
        served_at = '0;
        taken     = 1'b0;
        case (op)
            OP_TICK: begin
                if (door) begin
                    // An open door only counts down; the car stays put.
                    if (door_left <= tick_len) begin
                        door_left = '0;
                        door      = 1'b0;
                    end else begin
                        door_left = door_left - tick_len;
                    end
                end else if (pend == '0) begin
                    dir = DIR_IDLE;
                end else begin
                    // Idle car: take the only side, or the nearer one, ties going up.
                    if (dir == DIR_IDLE) begin
                        up_side   = pending_ahead(DIR_UP);
                        down_side = pending_ahead(DIR_DN);
                        if (up_side != '0 || down_side != '0) begin
                            if (down_side == '0) begin
                                dir = DIR_UP;
                            end else if (up_side == '0) begin
                                dir = DIR_DN;
                            end else begin
                                dir = (floor_gap(up_side, DIR_UP) <=
                                       floor_gap(down_side, DIR_DN)) ? DIR_UP : DIR_DN;
                            end
                            move_left = period;
                        end
                    end
                    if (pend[car_at-1]) begin
                        // Arrival: open, clear, then reverse or go idle if nothing ahead.
                        door              = 1'b1;
                        door_left         = hold;
                        pend[car_at-1]    = 1'b0;
                        served_at         = car_at;
                        move_left         = period;
                        if (pending_ahead(dir) == '0) begin
                            other = (dir == DIR_UP) ? DIR_DN : DIR_UP;
                            dir   = (pending_ahead(other) != '0) ? other : DIR_IDLE;
                        end
                    end else if (move_left != '0) begin
                        move_left = (move_left > tick_len) ? t_timer'(move_left - tick_len) : '0;
                    end else if (pending_ahead(dir) == '0) begin
                        dir = DIR_IDLE;
                    end else begin
                        car_at    = (dir == DIR_UP) ? t_floor'(car_at + 1) : t_floor'(car_at - 1);
                        move_left = period;
                    end
                end
            end
            OP_REQUEST: begin
                if (req >= 1 && req <= FLOORS && req != car_at && !pend[req-1]) begin
                    pend[req-1] = 1'b1;
                    taken       = 1'b1;
                end
            end
            OP_EXTEND: begin
                if (door) door_left = hold;
            end
            default: begin
                if (door) begin
                    door      = 1'b0;
                    door_left = '0;
                end
            end
        endcase
        rpt.car_floor    = car_at;
        rpt.direction    = dir;
        rpt.door_open    = door;
        rpt.served       = (served_at != '0);
        rpt.served_floor = served_at;
        rpt.taken        = taken;
        rpt.pending      = pend;
    endtask

    // Sends one beat, idling the input first when the pattern says so.
    task automatic send_item(input t_op op, input logic [3:0] flr);
        t_car_report rpt;
        @(negedge i_clk);
        while (calm_left == 0 && $urandom_range(0, 99) < src_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= {4'b0000, flr};
        do @(posedge i_clk); while (!o_s_tready);
        advance_car(op, flr, rpt);
        reports_due.push_back(rpt);
        items_sent++;
    endtask

    // Stops the input and waits until every predicted report has come back.
    task automatic wait_for_quiet();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        wait (reports_due.size() == 0);
        repeat (4) @(negedge i_clk);
    endtask

    // One APB write: setup cycle, then access cycle.
    task automatic write_setting(input t_reg_idx idx, input logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_DOOR_HOLD:   hold     = value[TIMER_W-1:0];
            REG_MOVE_PERIOD: period   = value[TIMER_W-1:0];
            REG_TICK:        tick_len = value[TICK_W-1:0];
            default: begin
                if (value[3:0] == 4'd0) car_at = t_floor'(1);
                else if (value[3:0] > FLOORS) car_at = t_floor'(FLOORS);
                else car_at = value[3:0];
            end
        endcase
        writes_done++;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic void check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $display("%0t ns: %s expected %0d actual %0d", $time, name, exp_v, act_v);
            mismatch_count++;
        end
    endfunction

    // Compare each result beat with the oldest report due.
    always @(posedge i_clk) begin
        t_car_report want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            results_seen++;
            if (reports_due.size() == 0) begin
                $display("%0t ns: result beat with none due, actual tdata %h",
                         $time, o_m_tdata);
                mismatch_count++;
            end else begin
                want = reports_due.pop_front();
                if (want.served) floors_served++;
                check_field("car_floor", want.car_floor, o_m_tdata[3:0]);
                check_field("direction", want.direction, o_m_tdata[5:4]);
                check_field("door_open", want.door_open, o_m_tdata[6]);
                check_field("served", want.served, o_m_tdata[7]);
                check_field("served_floor", want.served_floor, o_m_tdata[11:8]);
                check_field("request_taken", want.taken, o_m_tdata[12]);
                check_field("pending_floors", want.pending, o_m_tdata[24:13]);
                check_field("padding", 0, o_m_tdata[31:25]);
            end
        end
    end

    // Output back-pressure, with occasional stretches where neither side idles.
    always @(negedge i_clk) begin
        if (calm_left > 0) begin
            calm_left <= calm_left - 1;
        end else if ($urandom_range(0, 49) == 0) begin
            calm_left <= 40;
        end
        i_m_tready <= (calm_left > 0) || ($urandom_range(0, 99) >= sink_idle_pct);
    end

    // Watchdog on cycles without any accepted beat or register access.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || psel) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t ns: no beat accepted for %0d cycles", $time, quiet_cycles);
            $display("end of test: mismatches");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Bad requests, door commands with the door shut, and the reset settings.
    task automatic test_reset_state();
        send_item(OP_TICK, 4'd0);
        send_item(OP_REQUEST, 4'd0);
        send_item(OP_REQUEST, 4'd1);
        send_item(OP_REQUEST, 4'd13);
        send_item(OP_REQUEST, 4'd15);
        send_item(OP_REQUEST, 4'd12);
        send_item(OP_REQUEST, 4'd12);
        send_item(OP_EXTEND, 4'd7);
        send_item(OP_CLOSE, 4'd9);
        send_item(OP_TICK, 4'd0);
    endtask

    // New settings, a start floor below the pending top floor, then ticks, a door extend and a close.
    task automatic test_arrival_and_door();
        wait_for_quiet();
        write_setting(REG_DOOR_HOLD, 32'd60);
        write_setting(REG_MOVE_PERIOD, 32'd30);
        write_setting(REG_TICK, 32'd30);
        write_setting(REG_START_FLOOR, 32'd11);
        send_item(OP_TICK, 4'd0);
        send_item(OP_TICK, 4'd0);
        send_item(OP_TICK, 4'd0);
        send_item(OP_EXTEND, 4'd0);
        send_item(OP_TICK, 4'd0);
        send_item(OP_CLOSE, 4'd0);
    endtask

    // Start floor moves: serving in place, nothing ahead, clamping and a zero tick.
    task automatic test_start_floor_cases();
        send_item(OP_REQUEST, 4'd3);
        wait_for_quiet();
        write_setting(REG_START_FLOOR, 32'd3);
        send_item(OP_TICK, 4'd0);
        send_item(OP_TICK, 4'd0);
        send_item(OP_TICK, 4'd0);
        send_item(OP_REQUEST, 4'd6);
        send_item(OP_TICK, 4'd0);
        wait_for_quiet();
        write_setting(REG_START_FLOOR, 32'd9);
        send_item(OP_TICK, 4'd0);
        send_item(OP_TICK, 4'd0);
        wait_for_quiet();
        write_setting(REG_TICK, 32'd0);
        write_setting(REG_START_FLOOR, 32'd0);
        send_item(OP_TICK, 4'd0);
        send_item(OP_TICK, 4'd0);
        wait_for_quiet();
        write_setting(REG_START_FLOOR, 32'd15);
        send_item(OP_TICK, 4'd0);
    endtask

    // Random settings, then random traffic mostly of ticks and valid requests.
    task automatic test_random_traffic(input int src_pct, input int sink_pct, input int n_items);
        int pick;
        logic [31:0] value;
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        for (int seg = 0; seg < 3; seg++) begin
            wait_for_quiet();
            pick  = $urandom_range(0, 7);
            value = (pick == 0) ? 32'd0 : (pick == 1) ? 32'd65535 : $urandom_range(0, 150);
            write_setting(REG_DOOR_HOLD, value);
            pick  = $urandom_range(0, 7);
            value = (pick == 0) ? 32'd0 : (pick == 1) ? 32'd65535 : $urandom_range(0, 150);
            write_setting(REG_MOVE_PERIOD, value);
            pick = $urandom_range(0, 9);
            case (pick)
                0:       value = 32'd0;
                1:       value = 32'd1;
                2:       value = 32'd1000;
                3:       value = 32'd1023;
                default: value = $urandom_range(1, 80);
            endcase
            write_setting(REG_TICK, value);
            if ($urandom_range(0, 1) == 1) write_setting(REG_START_FLOOR, $urandom_range(0, 15));
            for (int n = 0; n < n_items / 3; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 55) begin
                    send_item(OP_TICK, 4'($urandom_range(0, 15)));
                end else if (pick < 85) begin
                    if ($urandom_range(0, 9) == 0) send_item(OP_REQUEST, 4'($urandom_range(0, 15)));
                    else send_item(OP_REQUEST, 4'($urandom_range(1, FLOORS)));
                end else if (pick < 93) begin
                    send_item(OP_EXTEND, 4'($urandom_range(0, 15)));
                end else begin
                    send_item(OP_CLOSE, 4'($urandom_range(0, 15)));
                end
            end
        end
    endtask

    initial begin
        // Inputs known from time zero; predictor starts from the reset state.
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_s_tuser  = '0;
        i_m_tready = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        hold       = DOOR_HOLD_RST;
        period     = MOVE_PERIOD_RST;
        tick_len   = TICK_RST;
        car_at     = START_FLOOR_RST;
        pend       = '0;
        dir        = DIR_IDLE;
        door       = 1'b0;
        door_left  = '0;
        move_left  = MOVE_PERIOD_RST;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_arrival_and_door();
        test_start_floor_cases();
        test_random_traffic(18, 77, 165);
        test_random_traffic(77, 18, 165);
        test_random_traffic(0, 0, 165);

        wait_for_quiet();
        repeat (8) @(posedge i_clk);
        $display("Covered %0d request, tick and door beats and %0d settings writes",
                 items_sent, writes_done);
        $display("over three idling patterns; %0d results checked, %0d floors served.",
                 results_seen, floors_served);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
